// ===== sv/mpm_pkg.sv =====
package mpm_pkg;

    localparam int COEFF_W = 30;
    localparam int INDEX_W = 6;
    localparam logic [COEFF_W-1:0] MOD_RESET = 30'd998244353;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_TERM,
        ST_MUL,
        ST_ACC,
        ST_RED,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic we_a;
        logic we_b;
        logic mul;
        logic acc_clr;
        logic acc_add;
        logic red_clr;
        logic red_step;
    } t_dp_cmd;

endpackage

// ===== sv/modular_polynomial_multiply.sv =====
// channel   direction  handshake                  payload
// in        in         i_in_valid / o_in_stall    i_which_seq, i_coeff, i_seq_last
// out       out        o_out_valid / i_out_stall  o_prod_coeff, o_prod_index, o_prod_last
// cfg       in         i_cfg_valid / o_cfg_ready  i_cfg_data (modulus)
//
// coefficients that do not close both sequences are taken while the block is loading;
// each product coefficient is built by a term scan over sequence a, a multiply and an
// accumulate per live term on the single 30x30 multiplier, and the bit-serial
// remainder unit over every accumulator bit; its beat is then held until taken
// reset is synchronous active low; stores need no clearing, counts and flags reset
// the input is stalled from the closing item until the last product beat is taken
module modular_polynomial_multiply #(
    parameter int MAX_LEN = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_which_seq,
    input  logic [mpm_pkg::COEFF_W-1:0]  i_coeff,
    input  logic                         i_seq_last,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [mpm_pkg::COEFF_W-1:0]  o_prod_coeff,
    output logic [mpm_pkg::INDEX_W-1:0]  o_prod_index,
    output logic                         o_prod_last,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [mpm_pkg::COEFF_W-1:0]  i_cfg_data
);

    import mpm_pkg::*;

    localparam int AW = MAX_LEN > 1 ? $clog2(MAX_LEN) : 1;

    t_dp_cmd        cmd;
    logic [AW-1:0]  waddr;
    logic [AW-1:0]  raddr_a;
    logic [AW-1:0]  raddr_b;

    assign o_cfg_ready = 1'b1;

    mpm_ctrl #(.MAX_LEN(MAX_LEN)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_which_seq  (i_which_seq),
        .i_seq_last   (i_seq_last),
        .o_in_stall   (o_in_stall),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_prod_index (o_prod_index),
        .o_prod_last  (o_prod_last),
        .o_cmd        (cmd),
        .o_waddr      (waddr),
        .o_raddr_a    (raddr_a),
        .o_raddr_b    (raddr_b)
    );

    mpm_datapath #(.MAX_LEN(MAX_LEN)) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .i_waddr    (waddr),
        .i_raddr_a  (raddr_a),
        .i_raddr_b  (raddr_b),
        .i_coeff    (i_coeff),
        .o_rem      (o_prod_coeff)
    );

endmodule

// ===== sv/mpm_ram.sv =====
module mpm_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/mpm_datapath.sv =====
module mpm_datapath #(
    parameter int MAX_LEN = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_cfg_we,
    input  logic [mpm_pkg::COEFF_W-1:0]                  i_cfg_data,
    input  mpm_pkg::t_dp_cmd                             i_cmd,
    input  logic [(MAX_LEN > 1 ? $clog2(MAX_LEN) : 1)-1:0] i_waddr,
    input  logic [(MAX_LEN > 1 ? $clog2(MAX_LEN) : 1)-1:0] i_raddr_a,
    input  logic [(MAX_LEN > 1 ? $clog2(MAX_LEN) : 1)-1:0] i_raddr_b,
    input  logic [mpm_pkg::COEFF_W-1:0]                  i_coeff,
    output logic [mpm_pkg::COEFF_W-1:0]                  o_rem
);

    import mpm_pkg::*;

    localparam int PW   = 2 * COEFF_W;
    localparam int SUMW = PW + (MAX_LEN > 1 ? $clog2(MAX_LEN) : 0);

    logic [COEFF_W-1:0] r_modulus;
    logic [COEFF_W-1:0] a_rdata;
    logic [COEFF_W-1:0] b_rdata;
    logic [PW-1:0]      r_prod;
    logic [SUMW-1:0]    r_acc;
    logic [SUMW-1:0]    n_acc;
    logic [COEFF_W-1:0] r_rem;
    logic [COEFF_W-1:0] n_rem;
    logic [COEFF_W:0]   mod_eff;
    logic [COEFF_W:0]   rem_dbl;

    mpm_ram #(.WIDTH(COEFF_W), .DEPTH(MAX_LEN)) u_store_a (
        .i_clk   (i_clk),
        .i_we    (i_cmd.we_a),
        .i_waddr (i_waddr),
        .i_wdata (i_coeff),
        .i_raddr (i_raddr_a),
        .o_rdata (a_rdata)
    );

    mpm_ram #(.WIDTH(COEFF_W), .DEPTH(MAX_LEN)) u_store_b (
        .i_clk   (i_clk),
        .i_we    (i_cmd.we_b),
        .i_waddr (i_waddr),
        .i_wdata (i_coeff),
        .i_raddr (i_raddr_b),
        .o_rdata (b_rdata)
    );

    // zero modulus acts as 2^30
    assign mod_eff = (r_modulus == '0) ? {1'b1, {COEFF_W{1'b0}}} : {1'b0, r_modulus};
    assign rem_dbl = {r_rem, r_acc[SUMW-1]};

    always_comb begin
        n_acc = r_acc;
        n_rem = r_rem;
        if (i_cmd.acc_clr) begin
            n_acc = '0;
        end else if (i_cmd.acc_add) begin
            n_acc = r_acc + SUMW'(r_prod);
        end else if (i_cmd.red_step) begin
            n_acc = {r_acc[SUMW-2:0], 1'b0};
        end
        if (i_cmd.red_clr) begin
            n_rem = '0;
        end else if (i_cmd.red_step) begin
            if (rem_dbl >= mod_eff) begin
                n_rem = COEFF_W'(rem_dbl - mod_eff);
            end else begin
                n_rem = COEFF_W'(rem_dbl);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MOD_RESET;
        end else if (i_cfg_we) begin
            r_modulus <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= PW'(a_rdata) * PW'(b_rdata);
        end
        r_acc <= n_acc;
        r_rem <= n_rem;
    end

    assign o_rem = r_rem;

endmodule

// ===== sv/mpm_ctrl.sv =====
module mpm_ctrl #(
    parameter int MAX_LEN = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_in_valid,
    input  logic                                         i_which_seq,
    input  logic                                         i_seq_last,
    output logic                                         o_in_stall,
    input  logic                                         i_out_stall,
    output logic                                         o_out_valid,
    output logic [mpm_pkg::INDEX_W-1:0]                  o_prod_index,
    output logic                                         o_prod_last,
    output mpm_pkg::t_dp_cmd                             o_cmd,
    output logic [(MAX_LEN > 1 ? $clog2(MAX_LEN) : 1)-1:0] o_waddr,
    output logic [(MAX_LEN > 1 ? $clog2(MAX_LEN) : 1)-1:0] o_raddr_a,
    output logic [(MAX_LEN > 1 ? $clog2(MAX_LEN) : 1)-1:0] o_raddr_b
);

    import mpm_pkg::*;

    localparam int AW   = MAX_LEN > 1 ? $clog2(MAX_LEN) : 1;
    localparam int CW   = $clog2(MAX_LEN + 1);
    localparam int KW   = $clog2(2 * MAX_LEN + 1);
    localparam int SUMW = 2 * COEFF_W + (MAX_LEN > 1 ? $clog2(MAX_LEN) : 0);
    localparam int BW   = $clog2(SUMW);

    t_state         r_state;
    t_state         n_state;
    logic [CW-1:0]  r_cnt_a;
    logic [CW-1:0]  n_cnt_a;
    logic [CW-1:0]  r_cnt_b;
    logic [CW-1:0]  n_cnt_b;
    logic           r_closed_a;
    logic           n_closed_a;
    logic           r_closed_b;
    logic           n_closed_b;
    logic [KW-1:0]  r_k;
    logic [KW-1:0]  n_k;
    logic [CW-1:0]  r_i;
    logic [CW-1:0]  n_i;
    logic [BW-1:0]  r_bit;
    logic [BW-1:0]  n_bit;

    logic           accept;
    logic           sel_closed;
    logic           other_closed;
    logic [CW-1:0]  sel_cnt;
    logic           start;
    logic [KW-1:0]  total;
    logic [KW-1:0]  n_len;
    logic           len_found;
    logic           last_k;
    logic           i_done;
    logic [KW-1:0]  j_idx;
    logic           term_ok;

    assign accept       = i_in_valid && (r_state == ST_LOAD);
    assign sel_closed   = i_which_seq ? r_closed_b : r_closed_a;
    assign other_closed = i_which_seq ? r_closed_a : r_closed_b;
    assign sel_cnt      = i_which_seq ? r_cnt_b : r_cnt_a;
    assign start        = accept && !sel_closed && i_seq_last && other_closed;

    assign total = KW'(r_cnt_a) + KW'(r_cnt_b);

    // smallest power of two not below total
    always_comb begin
        n_len     = '0;
        len_found = 1'b0;
        for (int l = 0; l < KW; l++) begin
            if (!len_found && ((KW'(1) << l) >= total)) begin
                n_len     = KW'(1) << l;
                len_found = 1'b1;
            end
        end
    end

    assign last_k  = (r_k + KW'(1)) == n_len;
    assign i_done  = r_i == r_cnt_a;
    assign j_idx   = r_k - KW'(r_i);
    assign term_ok = (KW'(r_i) <= r_k) && (j_idx < KW'(r_cnt_b));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (start) begin
                    n_state = ST_TERM;
                end
            end
            ST_TERM: begin
                if (i_done) begin
                    n_state = ST_RED;
                end else if (term_ok) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                n_state = ST_TERM;
            end
            ST_RED: begin
                if (r_bit == '0) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!i_out_stall) begin
                    n_state = last_k ? ST_LOAD : ST_TERM;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                o_in_stall    = 1'b0;
                o_cmd.we_a    = accept && !i_which_seq && !r_closed_a
                                && (r_cnt_a < CW'(MAX_LEN));
                o_cmd.we_b    = accept && i_which_seq && !r_closed_b
                                && (r_cnt_b < CW'(MAX_LEN));
                o_cmd.acc_clr = start;
            end
            ST_TERM: begin
                o_cmd.red_clr = i_done;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
            end
            ST_ACC: begin
                o_cmd.acc_add = 1'b1;
            end
            ST_RED: begin
                o_cmd.red_step = 1'b1;
            end
            ST_OUT: begin
                o_out_valid   = 1'b1;
                o_cmd.acc_clr = !i_out_stall;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_comb begin
        n_cnt_a    = r_cnt_a;
        n_cnt_b    = r_cnt_b;
        n_closed_a = r_closed_a;
        n_closed_b = r_closed_b;
        n_k        = r_k;
        n_i        = r_i;
        n_bit      = r_bit;
        unique case (r_state)
            ST_LOAD: begin
                if (o_cmd.we_a) begin
                    n_cnt_a = r_cnt_a + CW'(1);
                end
                if (o_cmd.we_b) begin
                    n_cnt_b = r_cnt_b + CW'(1);
                end
                if (accept && !sel_closed && i_seq_last) begin
                    if (i_which_seq) begin
                        n_closed_b = 1'b1;
                    end else begin
                        n_closed_a = 1'b1;
                    end
                end
                if (start) begin
                    n_k = '0;
                    n_i = '0;
                end
            end
            ST_TERM: begin
                if (i_done) begin
                    n_bit = BW'(SUMW - 1);
                end else if (!term_ok) begin
                    n_i = r_i + CW'(1);
                end
            end
            ST_MUL: begin
                n_i = r_i;
            end
            ST_ACC: begin
                n_i = r_i + CW'(1);
            end
            ST_RED: begin
                if (r_bit != '0) begin
                    n_bit = r_bit - BW'(1);
                end
            end
            ST_OUT: begin
                if (!i_out_stall) begin
                    if (last_k) begin
                        n_cnt_a    = '0;
                        n_cnt_b    = '0;
                        n_closed_a = 1'b0;
                        n_closed_b = 1'b0;
                    end else begin
                        n_k = r_k + KW'(1);
                        n_i = '0;
                    end
                end
            end
            default: begin
                n_i = r_i;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_cnt_a    <= '0;
            r_cnt_b    <= '0;
            r_closed_a <= 1'b0;
            r_closed_b <= 1'b0;
            r_k        <= '0;
            r_i        <= '0;
            r_bit      <= '0;
        end else begin
            r_state    <= n_state;
            r_cnt_a    <= n_cnt_a;
            r_cnt_b    <= n_cnt_b;
            r_closed_a <= n_closed_a;
            r_closed_b <= n_closed_b;
            r_k        <= n_k;
            r_i        <= n_i;
            r_bit      <= n_bit;
        end
    end

    assign o_waddr      = sel_cnt[AW-1:0];
    assign o_raddr_a    = r_i[AW-1:0];
    assign o_raddr_b    = j_idx[AW-1:0];
    assign o_prod_index = INDEX_W'(r_k);
    assign o_prod_last  = last_k;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int COEFF_W = mpm_pkg::COEFF_W;
    localparam int INDEX_W = mpm_pkg::INDEX_W;
    localparam int MAX_LEN = 16;
    localparam logic SEQ_A = 1'b0;
    localparam logic SEQ_B = 1'b1;
    localparam logic [COEFF_W-1:0] COEFF_MAX = '1;
    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam int unsigned PHASE_ITEMS = 1;

    typedef struct packed {
        logic               which;
        logic [COEFF_W-1:0] coeff;
        logic               last;
    } coeff_beat_t;

    typedef struct packed {
        logic [COEFF_W-1:0] coeff;
        logic [INDEX_W-1:0] index;
        logic               last;
    } product_beat_t;

    logic i_clk;
    logic rst_n = 1'b0;

    logic               in_valid = 1'b0;
    logic               in_which = 1'b0;
    logic [COEFF_W-1:0] in_coeff = '0;
    logic               in_last = 1'b0;
    logic               out_stall = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [COEFF_W-1:0] cfg_data = '0;

    logic               o_in_stall;
    logic               o_out_valid;
    logic [COEFF_W-1:0] o_prod_coeff;
    logic [INDEX_W-1:0] o_prod_index;
    logic               o_prod_last;
    logic               o_cfg_ready;

    modular_polynomial_multiply #(
        .MAX_LEN(MAX_LEN)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_which_seq (in_which),
        .i_coeff     (in_coeff),
        .i_seq_last  (in_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_prod_coeff(o_prod_coeff),
        .o_prod_index(o_prod_index),
        .o_prod_last (o_prod_last),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    coeff_beat_t   coeff_q[$];
    product_beat_t product_q[$];

    int unsigned pushed_count = 0;
    int unsigned accepted_count = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    logic        in_fire = 1'b0;
    logic        cfg_fire = 1'b0;

    // shadow of the block state
    logic [COEFF_W-1:0] modulus_shadow = mpm_pkg::MOD_RESET;
    logic [COEFF_W-1:0] a_store [MAX_LEN];
    logic [COEFF_W-1:0] b_store [MAX_LEN];
    int unsigned        a_len = 0;
    int unsigned        b_len = 0;
    logic               a_closed = 1'b0;
    logic               b_closed = 1'b0;

    function automatic logic [63:0] mod_reduce(input logic [63:0] x, input logic [63:0] m);
        if (m == 0) begin
            return x & 64'(COEFF_MAX);
        end
        return x % m;
    endfunction

    function automatic void convolve_product();
        int unsigned   total;
        int unsigned   n;
        int unsigned   j;
        logic [63:0]   m;
        logic [63:0]   acc;
        logic [63:0]   p;
        product_beat_t beat;
        total = a_len + b_len;
        n = 1;
        m = 64'(modulus_shadow);
        while (n < total) n = n << 1;
        for (int unsigned k = 0; k < n; k++) begin
            acc = '0;
            for (int unsigned i = 0; i < a_len; i++) begin
                if (k >= i) begin
                    j = k - i;
                    if (j < b_len) begin
                        p = 64'(a_store[i]);
                        p = p * 64'(b_store[j]);
                        acc = mod_reduce(mod_reduce(p, m) + acc, m);
                    end
                end
            end
            beat.coeff = acc[COEFF_W-1:0];
            beat.index = k[INDEX_W-1:0];
            beat.last = (k + 1 == n);
            product_q.push_back(beat);
        end
    endfunction

    function automatic void absorb_coeff(input logic which, input logic [COEFF_W-1:0] c,
                                         input logic last);
        if (which == SEQ_A) begin
            if (a_closed) return;
            if (a_len < MAX_LEN) begin
                a_store[a_len] = c;
                a_len++;
            end
            if (last) a_closed = 1'b1;
        end else begin
            if (b_closed) return;
            if (b_len < MAX_LEN) begin
                b_store[b_len] = c;
                b_len++;
            end
            if (last) b_closed = 1'b1;
        end
        if (!(a_closed && b_closed)) return;
        convolve_product();
        a_len = 0;
        b_len = 0;
        a_closed = 1'b0;
        b_closed = 1'b0;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // input driver: bursts of beats with random gaps
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;

    always @(negedge i_clk) begin : drive_in
        coeff_beat_t beat;
        if (rst_n && (!in_valid || in_fire)) begin
            if (gap_left != 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (coeff_q.size() != 0) begin
                beat = coeff_q.pop_front();
                in_valid <= 1'b1;
                in_which <= beat.which;
                in_coeff <= beat.coeff;
                in_last <= beat.last;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // output stall pattern in one of four randomly chosen modes
    int unsigned stall_tick = 0;
    int unsigned stall_mode = 0;

    always @(negedge i_clk) begin
        stall_tick++;
        if (stall_tick % 128 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 2) == 0);
            2: out_stall <= ((stall_tick / 4) % 2 == 1);
            default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    always @(posedge i_clk) begin : monitor
        product_beat_t want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("modular_polynomial_multiply verification failed");
            $finish;
        end else begin
            in_fire <= rst_n && in_valid && !o_in_stall;
            cfg_fire <= rst_n && cfg_valid && o_cfg_ready;
            if (rst_n) begin
                if (cfg_valid && o_cfg_ready) modulus_shadow = cfg_data;
                if (in_valid && !o_in_stall) begin
                    accepted_count++;
                    absorb_coeff(in_which, in_coeff, in_last);
                end
                if (o_out_valid && !out_stall) begin
                    if (product_q.size() == 0) begin
                        $error("unexpected product beat: index %0d coeff %0d",
                               o_prod_index, o_prod_coeff);
                        error_count++;
                    end else begin
                        want = product_q.pop_front();
                        if (o_prod_coeff !== want.coeff) begin
                            $error("prod_coeff: expected %0d, actual %0d",
                                   want.coeff, o_prod_coeff);
                            error_count++;
                        end
                        if (o_prod_index !== want.index) begin
                            $error("prod_index: expected %0d, actual %0d",
                                   want.index, o_prod_index);
                            error_count++;
                        end
                        if (o_prod_last !== want.last) begin
                            $error("prod_last: expected %0d, actual %0d",
                                   want.last, o_prod_last);
                            error_count++;
                        end
                    end
                end
            end
        end
    end

    task automatic send_beat(input logic which, input logic [COEFF_W-1:0] c, input logic last);
        coeff_beat_t beat;
        beat.which = which;
        beat.coeff = c;
        beat.last = last;
        coeff_q.push_back(beat);
        pushed_count++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (accepted_count != pushed_count || product_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_modulus(input logic [COEFF_W-1:0] value);
        wait_idle();
        repeat (8) @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(negedge i_clk);
        while (!cfg_fire) @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r < 10) return $urandom_range(1, 4);
        if (r < 15) return $urandom_range(5, 16);
        return $urandom_range(17, 20);
    endfunction

    function automatic logic [COEFF_W-1:0] pick_coeff();
        logic [COEFF_W-1:0] v;
        v = 30'($urandom);
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = COEFF_MAX;
            2: v = v % 30'd16;
            default: ;
        endcase
        return v;
    endfunction

    // one pair of sequences, randomly interleaved, with stray beats to a closed one
    task automatic queue_pair(inout int unsigned count);
        int unsigned len_a;
        int unsigned len_b;
        int unsigned ia;
        int unsigned ib;
        len_a = pick_len();
        len_b = pick_len();
        ia = 0;
        ib = 0;
        count += len_a + len_b;
        while (ia < len_a || ib < len_b) begin
            if (ib >= len_b || (ia < len_a && $urandom_range(0, 1) == 0)) begin
                ia++;
                send_beat(SEQ_A, pick_coeff(), ia == len_a);
                if (ia == len_a && ib < len_b && $urandom_range(0, 5) == 0) begin
                    send_beat(SEQ_A, pick_coeff(), 1'($urandom_range(0, 1)));
                end
            end else begin
                ib++;
                send_beat(SEQ_B, pick_coeff(), ib == len_b);
                if (ib == len_b && ia < len_a && $urandom_range(0, 5) == 0) begin
                    send_beat(SEQ_B, pick_coeff(), 1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    initial begin : stimulus
        logic [COEFF_W-1:0] mod_plan [8];
        int unsigned        phase_items;
        mod_plan = '{30'd2, COEFF_MAX, 30'd1, 30'd0, mpm_pkg::MOD_RESET,
                     30'd3, 30'd65537, 30'd0};
        mod_plan[7] = 30'($urandom);
        repeat (8) @(negedge i_clk);
        rst_n <= 1'b1;

        // full store: the seventeenth coefficient is dropped but still closes
        for (int i = 0; i < 17; i++) begin
            send_beat(SEQ_A, (i % 2 == 1) ? COEFF_MAX : 30'(i), i == 16);
        end
        // closed sequence ignores further beats
        send_beat(SEQ_A, 30'd123, 1'b1);
        send_beat(SEQ_B, COEFF_MAX, 1'b1);
        // second sequence closed first
        send_beat(SEQ_B, 30'd0, 1'b1);
        send_beat(SEQ_A, COEFF_MAX, 1'b1);
        // coefficients at and above the modulus
        send_beat(SEQ_A, COEFF_MAX, 1'b0);
        send_beat(SEQ_B, 30'd1, 1'b0);
        send_beat(SEQ_B, mpm_pkg::MOD_RESET, 1'b1);
        send_beat(SEQ_A, mpm_pkg::MOD_RESET - 30'd1, 1'b1);

        for (int p = 0; p < 8; p++) begin
            write_modulus(mod_plan[p]);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) queue_pair(phase_items);
        end

        wait_idle();
        repeat (300) @(negedge i_clk);
        if (error_count == 0) begin
            $display("modular_polynomial_multiply verification clean");
        end else begin
            $display("modular_polynomial_multiply verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/mpm_pkg.sv
sv/mpm_ram.sv
sv/mpm_datapath.sv
sv/mpm_ctrl.sv
sv/modular_polynomial_multiply.sv
bench/testbench.sv
